/* rtl/tcp_receive_window_trim_top_defines.svh */
// Assertion macros for the TCP receive window trim block.
// Used by tcp_receive_window_trim_top; expects clk and rst_n in scope.
`ifndef TCP_RECEIVE_WINDOW_TRIM_TOP_DEFINES_SVH
`define TCP_RECEIVE_WINDOW_TRIM_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TWT_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, disabled in reset
`define TWT_ASSERT_NXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* rtl/twt_pkg.sv */
// Shared widths, flag bit positions and stage word types for the
// TCP receive window trim pipeline. No dependencies.
package twt_pkg;

    localparam int SEQ_W   = 32;
    localparam int WIN_W   = 16;
    localparam int LEN_W   = 16;
    localparam int FLG_W   = 6;
    localparam int URG_W   = 16;
    localparam int SPAN_W  = 17;
    localparam int DISC_W  = 17;
    localparam int SMALL_W = 18;

    localparam int FL_FIN = 0;
    localparam int FL_SYN = 1;
    localparam int FL_URG = 5;

    typedef struct packed {
        logic [SEQ_W-1:0] nxt;
        logic [WIN_W-1:0] wnd;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [FLG_W-1:0] flags;
        logic [URG_W-1:0] up;
    } twt_in_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  d;        // seq - nxt
        logic [SPAN_W-1:0] span_m1;
        logic              span_nz;
        logic              wz;
        logic              eq;
        logic [WIN_W-1:0]  wnd;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [FLG_W-1:0]  flags;
        logic [URG_W-1:0]  up;
    } twt_s1_t;

    typedef struct packed {
        logic                ok;
        logic                wz;
        logic                dup_pos;
        logic [DISC_W-1:0]   dup_full;  // duplicate count, SYN included
        logic [DISC_W-1:0]   dup_rem;   // duplicate payload after SYN
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic [FLG_W-1:0]    flags;
        logic [URG_W-1:0]    up;
        logic [SEQ_W-1:0]    d;
        logic [SMALL_W-1:0]  small_ofs; // len + syn - wnd, two's complement
    } twt_s2_t;

    typedef struct packed {
        logic              ok;
        logic              wz;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [FLG_W-1:0]  flags;
        logic [URG_W-1:0]  up;
        logic [DISC_W-1:0] disc;
        logic [SEQ_W-1:0]  exd;       // right end minus right window edge
    } twt_s3_t;

    typedef struct packed {
        logic              accepted;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [FLG_W-1:0]  flags;
        logic [URG_W-1:0]  up;
        logic [DISC_W-1:0] disc;
    } twt_out_t;

endpackage

/* rtl/twt_diff.sv */
// Stage 1: sequence difference, segment span and zero-window checks.
// Depends on twt_pkg.
module twt_diff (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              adv,
    input  twt_pkg::twt_in_t  in_data,
    output logic              out_valid,
    output twt_pkg::twt_s1_t  out_data
);
    import twt_pkg::*;

    twt_s1_t           s1_next;
    twt_s1_t           s1_reg;
    logic              valid_reg;
    logic [SPAN_W-1:0] span;

    always_comb
    begin
        span = SPAN_W'(in_data.len) + SPAN_W'(in_data.flags[FL_SYN])
             + SPAN_W'(in_data.flags[FL_FIN]);
        s1_next.d       = in_data.seq - in_data.nxt;
        s1_next.span_m1 = span - SPAN_W'(1);
        s1_next.span_nz = (span != '0);
        s1_next.wz      = (in_data.wnd == '0);
        s1_next.eq      = (in_data.seq == in_data.nxt);
        s1_next.wnd     = in_data.wnd;
        s1_next.seq     = in_data.seq;
        s1_next.len     = in_data.len;
        s1_next.flags   = in_data.flags;
        s1_next.up      = in_data.up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            s1_reg <= s1_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = s1_reg;

endmodule

/* rtl/twt_accept.sv */
// Stage 2: acceptability decision and leading SYN consumption.
// Depends on twt_pkg.
module twt_accept (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              adv,
    input  twt_pkg::twt_s1_t  in_data,
    output logic              out_valid,
    output twt_pkg::twt_s2_t  out_data
);
    import twt_pkg::*;

    twt_s2_t          s2_next;
    twt_s2_t          s2_reg;
    logic             valid_reg;
    logic [SEQ_W-1:0] negd;
    logic [SEQ_W-1:0] last_rel;
    logic             in_seq;
    logic             in_last;
    logic             dup_lt;
    logic             dup_pos;
    logic             syn_cons;

    always_comb
    begin
        negd     = SEQ_W'(0) - in_data.d;
        last_rel = in_data.d + SEQ_W'(in_data.span_m1);
        in_seq   = (in_data.d < SEQ_W'(in_data.wnd));
        in_last  = (last_rel < SEQ_W'(in_data.wnd));
        // nxt - seq < span, span known nonzero here
        dup_lt   = (negd <= SEQ_W'(in_data.span_m1));
        // nxt - seq is serially positive
        dup_pos  = !in_data.wz && in_data.d[SEQ_W-1] && (in_data.d[SEQ_W-2:0] != '0);
        syn_cons = dup_pos && in_data.flags[FL_SYN];

        s2_next.ok = in_data.wz ? (!in_data.span_nz && in_data.eq)
                   : (in_seq || (in_data.span_nz && (in_last || dup_lt)));
        s2_next.wz       = in_data.wz;
        s2_next.dup_pos  = dup_pos;
        s2_next.dup_full = negd[DISC_W-1:0];
        s2_next.dup_rem  = ~in_data.d[DISC_W-1:0] + DISC_W'(!syn_cons);
        s2_next.seq      = in_data.seq + SEQ_W'(syn_cons);
        s2_next.len      = in_data.len;
        s2_next.flags    = in_data.flags;
        s2_next.up       = in_data.up;
        if (syn_cons)
        begin
            s2_next.flags[FL_SYN] = 1'b0;
            if (in_data.up > URG_W'(1))
                s2_next.up = in_data.up - URG_W'(1);
            else
                s2_next.flags[FL_URG] = 1'b0;
        end
        s2_next.d         = in_data.d;
        s2_next.small_ofs = SMALL_W'(in_data.len) + SMALL_W'(syn_cons)
                          - SMALL_W'(in_data.wnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            s2_reg <= s2_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = s2_reg;

endmodule

/* rtl/twt_lead.sv */
// Stage 3: duplicate payload trim with urgent pointer update, and the
// right-edge overshoot. Depends on twt_pkg.
module twt_lead (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              adv,
    input  twt_pkg::twt_s2_t  in_data,
    output logic              out_valid,
    output twt_pkg::twt_s3_t  out_data
);
    import twt_pkg::*;

    twt_s3_t          s3_next;
    twt_s3_t          s3_reg;
    logic             valid_reg;
    logic             trim_en;
    logic [LEN_W-1:0] dclamp;

    always_comb
    begin
        trim_en = in_data.dup_pos && (in_data.dup_rem != '0);
        dclamp  = (in_data.dup_rem > DISC_W'(in_data.len)) ? in_data.len
                : in_data.dup_rem[LEN_W-1:0];

        s3_next.ok    = in_data.ok;
        s3_next.wz    = in_data.wz;
        s3_next.seq   = in_data.seq;
        s3_next.len   = in_data.len;
        s3_next.flags = in_data.flags;
        s3_next.up    = in_data.up;
        if (trim_en)
        begin
            s3_next.seq = in_data.seq + SEQ_W'(dclamp);
            s3_next.len = in_data.len - dclamp;
            if (in_data.up > dclamp)
                s3_next.up = in_data.up - dclamp;
            else
            begin
                s3_next.flags[FL_URG] = 1'b0;
                s3_next.up            = '0;
            end
        end
        s3_next.disc = in_data.dup_pos ? in_data.dup_full : '0;
        // end of data is unchanged by the leading trim
        s3_next.exd  = in_data.d + {{(SEQ_W-SMALL_W){in_data.small_ofs[SMALL_W-1]}},
                                    in_data.small_ofs};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            s3_reg <= s3_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = s3_reg;

endmodule

/* rtl/twt_edge.sv */
// Stage 4: cut at the right window edge, final masking, output register.
// Depends on twt_pkg.
module twt_edge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              adv,
    input  twt_pkg::twt_s3_t  in_data,
    output logic              out_valid,
    output twt_pkg::twt_out_t out_data
);
    import twt_pkg::*;

    twt_out_t         out_next;
    twt_out_t         out_reg;
    logic             valid_reg;
    logic             ex_pos;
    logic [LEN_W-1:0] excess;

    always_comb
    begin
        ex_pos = !in_data.wz && (in_data.exd != '0) && !in_data.exd[SEQ_W-1];
        excess = '0;
        if (ex_pos)
            excess = (in_data.exd > SEQ_W'(in_data.len)) ? in_data.len
                   : in_data.exd[LEN_W-1:0];

        out_next = '0;
        if (in_data.ok)
        begin
            out_next.accepted = 1'b1;
            out_next.seq      = in_data.seq;
            out_next.len      = in_data.len - excess;
            out_next.flags    = in_data.flags;
            out_next.up       = in_data.up;
            out_next.disc     = in_data.disc + DISC_W'(excess);
            if (ex_pos)
                out_next.flags[FL_FIN] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            out_reg <= out_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/tcp_receive_window_trim_top.sv */
// TCP receive segment acceptability check and window trim.
// Input word: next_expected, recv_window and one segment header
// (seq_in, length_in, flags_in, urgent_in), taken when in_valid is high
// and in_stall is low. Result word: accepted plus trimmed seq_out,
// length_out, flags_out, urgent_out and the discarded octet count,
// delivered when out_valid is high and out_stall is low.
// An accepted input word reaches out_valid through four register
// stages: difference/span, accept decision and SYN consumption,
// leading duplicate trim, right edge cut with output register.
// One word per cycle when out_stall is low; no state carries across segments.
// A rejected segment still gives a result word, with accepted low and
// every other field zero.
// Reset clears all stage valid bits; the pipeline is empty afterward.
// When out_stall is high the output word holds, stages behind it fill
// their bubbles and in_stall rises once every stage is occupied.
// Depends on twt_pkg, twt_diff, twt_accept, twt_lead, twt_edge.
`include "tcp_receive_window_trim_top_defines.svh"

module tcp_receive_window_trim_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [twt_pkg::SEQ_W-1:0]   next_expected,
    input  logic [twt_pkg::WIN_W-1:0]   recv_window,
    input  logic [twt_pkg::SEQ_W-1:0]   seq_in,
    input  logic [twt_pkg::LEN_W-1:0]   length_in,
    input  logic [twt_pkg::FLG_W-1:0]   flags_in,
    input  logic [twt_pkg::URG_W-1:0]   urgent_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        accepted,
    output logic [twt_pkg::SEQ_W-1:0]   seq_out,
    output logic [twt_pkg::LEN_W-1:0]   length_out,
    output logic [twt_pkg::FLG_W-1:0]   flags_out,
    output logic [twt_pkg::URG_W-1:0]   urgent_out,
    output logic [twt_pkg::DISC_W-1:0]  discarded
);
    import twt_pkg::*;

    twt_in_t  in_word;
    twt_s1_t  s1;
    twt_s2_t  s2;
    twt_s3_t  s3;
    twt_out_t res;
    logic     v1, v2, v3, v4;
    logic     en1, en2, en3, en4;
    logic     rej_clean;

    // a stage loads when it is empty or the one ahead of it moves
    assign en4 = !v4 || !out_stall;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;
    assign in_stall = !en1;

    assign in_word.nxt   = next_expected;
    assign in_word.wnd   = recv_window;
    assign in_word.seq   = seq_in;
    assign in_word.len   = length_in;
    assign in_word.flags = flags_in;
    assign in_word.up    = urgent_in;

    twt_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .adv       (en1),
        .in_data   (in_word),
        .out_valid (v1),
        .out_data  (s1)
    );

    twt_accept u_accept (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .adv       (en2),
        .in_data   (s1),
        .out_valid (v2),
        .out_data  (s2)
    );

    twt_lead u_lead (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .adv       (en3),
        .in_data   (s2),
        .out_valid (v3),
        .out_data  (s3)
    );

    twt_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .adv       (en4),
        .in_data   (s3),
        .out_valid (v4),
        .out_data  (res)
    );

    assign out_valid  = v4;
    assign accepted   = res.accepted;
    assign seq_out    = res.seq;
    assign length_out = res.len;
    assign flags_out  = res.flags;
    assign urgent_out = res.up;
    assign discarded  = res.disc;

    assign rej_clean = (seq_out == '0) && (length_out == '0) && (flags_out == '0)
                    && (urgent_out == '0) && (discarded == '0);

    `TWT_ASSERT_NXT(a_in_lands, in_valid && !in_stall, v1, "accepted input word not in stage 1")
    `TWT_ASSERT_NXT(a_s3_holds, v3 && !en4, v3, "stage 3 word lost while output blocked")
    `TWT_ASSERT_IMP(a_reject_zero, out_valid && !accepted, rej_clean, "rejected word not zero")

endmodule

/* dv/tb_tcp_receive_window_trim_top.sv */
// Self-checking testbench for tcp_receive_window_trim_top: segment acceptability and window trim.
// Needs twt_pkg and the RTL. Predicts every result word and compares it field by field.
`timescale 1ns / 100ps

module tb_tcp_receive_window_trim_top;
    import twt_pkg::*;

    localparam int PIPE_LAT  = 4;
    localparam int MAX_CYC   = 400000;
    localparam int MAX_PRINT = 30;

    localparam logic [FLG_W-1:0] F_FIN = 6'h01 << FL_FIN;
    localparam logic [FLG_W-1:0] F_SYN = 6'h01 << FL_SYN;
    localparam logic [FLG_W-1:0] F_RST = 6'h04;
    localparam logic [FLG_W-1:0] F_PSH = 6'h08;
    localparam logic [FLG_W-1:0] F_ACK = 6'h10;
    localparam logic [FLG_W-1:0] F_URG = 6'h01 << FL_URG;

    typedef enum int {SEG_INSIDE, SEG_LEFT, SEG_RIGHT, SEG_ZERO_WIN, SEG_NOISE} seg_kind_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [SEQ_W-1:0]  next_expected = '0;
    logic [WIN_W-1:0]  recv_window = '0;
    logic [SEQ_W-1:0]  seq_in = '0;
    logic [LEN_W-1:0]  length_in = '0;
    logic [FLG_W-1:0]  flags_in = '0;
    logic [URG_W-1:0]  urgent_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              accepted;
    logic [SEQ_W-1:0]  seq_out;
    logic [LEN_W-1:0]  length_out;
    logic [FLG_W-1:0]  flags_out;
    logic [URG_W-1:0]  urgent_out;
    logic [DISC_W-1:0] discarded;

    twt_out_t trimmed_q[$];
    twt_out_t got_word;
    twt_out_t want_word;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       n_err = 0;
    int       n_in = 0;
    int       n_out = 0;
    int       n_kept = 0;
    int       n_trimmed = 0;
    int       n_zero_win = 0;
    int       cycles = 0;

    tcp_receive_window_trim_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .next_expected (next_expected),
        .recv_window   (recv_window),
        .seq_in        (seq_in),
        .length_in     (length_in),
        .flags_in      (flags_in),
        .urgent_in     (urgent_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .seq_out       (seq_out),
        .length_out    (length_out),
        .flags_out     (flags_out),
        .urgent_out    (urgent_out),
        .discarded     (discarded)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, trimmed_q.size());
            $display("FAIL tcp_receive_window_trim_top");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // strictly positive serial difference
    function automatic logic serial_pos(logic [31:0] d);
        return d != 0 && !d[31];
    endfunction

    function automatic twt_out_t trim_segment(twt_in_t s);
        twt_out_t         r;
        logic [31:0]      seq, len, up, dup, exd, excess, disc, span, last;
        logic [FLG_W-1:0] fl;
        logic             ok;
        r    = '0;
        seq  = s.seq;
        len  = {16'd0, s.len};
        up   = {16'd0, s.up};
        fl   = s.flags;
        disc = 0;
        span = len + fl[FL_SYN] + fl[FL_FIN];
        if (s.wnd == '0)
        begin
            // empty in-order segment passes untouched
            if (span == 0 && s.seq == s.nxt)
            begin
                r.accepted = 1'b1;
                r.seq      = s.seq;
                r.len      = s.len;
                r.flags    = s.flags;
                r.up       = s.up;
            end
            return r;
        end
        dup = s.seq - s.nxt;
        ok  = dup < {16'd0, s.wnd};
        if (!ok && span != 0)
        begin
            last = s.seq + span - 1;
            dup  = last - s.nxt;
            ok   = dup < {16'd0, s.wnd};
            dup  = s.nxt - s.seq;
            ok   = ok || (dup < span);
        end
        if (!ok)
            return r;
        dup = s.nxt - s.seq;
        if (serial_pos(dup))
        begin
            disc = disc + dup;
            if (fl[FL_SYN])
            begin
                fl[FL_SYN] = 1'b0;
                seq = seq + 1;
                if (up > 1)
                    up = up - 1;
                else
                    fl[FL_URG] = 1'b0;
                dup = dup - 1;
            end
            if (dup != 0)
            begin
                if (dup > len)
                    dup = len;
                seq = seq + dup;
                len = len - dup;
                if (up > dup)
                    up = up - dup;
                else
                begin
                    fl[FL_URG] = 1'b0;
                    up = 0;
                end
            end
        end
        exd = (seq + len) - (s.nxt + {16'd0, s.wnd});
        if (serial_pos(exd))
        begin
            excess = (exd > len) ? len : exd;
            disc = disc + excess;
            len = len - excess;
            fl[FL_FIN] = 1'b0;
        end
        r.accepted = 1'b1;
        r.seq      = seq;
        r.len      = len[LEN_W-1:0];
        r.flags    = fl;
        r.up       = up[URG_W-1:0];
        r.disc     = disc[DISC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_err++;
        if (n_err <= MAX_PRINT)
            $display("mismatch on word %0d, %s: got %0h expected %0h", n_out, what, got, want);
    endtask

    // input words are predicted on accept; result words checked against the oldest
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                trimmed_q.push_back(trim_segment({next_expected, recv_window, seq_in,
                                                  length_in, flags_in, urgent_in}));
                n_in++;
                if (recv_window == '0)
                    n_zero_win++;
            end
            if (out_valid && !out_stall)
            begin
                got_word = {accepted, seq_out, length_out, flags_out, urgent_out, discarded};
                if (trimmed_q.size() == 0)
                    report_mismatch("unexpected word", got_word.seq, 0);
                else
                begin
                    want_word = trimmed_q.pop_front();
                    if (got_word.accepted !== want_word.accepted)
                        report_mismatch("accepted", 32'(got_word.accepted),
                                        32'(want_word.accepted));
                    if (got_word.seq !== want_word.seq)
                        report_mismatch("seq_out", got_word.seq, want_word.seq);
                    if (got_word.len !== want_word.len)
                        report_mismatch("length_out", 32'(got_word.len), 32'(want_word.len));
                    if (got_word.flags !== want_word.flags)
                        report_mismatch("flags_out", 32'(got_word.flags), 32'(want_word.flags));
                    if (got_word.up !== want_word.up)
                        report_mismatch("urgent_out", 32'(got_word.up), 32'(want_word.up));
                    if (got_word.disc !== want_word.disc)
                        report_mismatch("discarded", 32'(got_word.disc), 32'(want_word.disc));
                    if (want_word.accepted)
                        n_kept++;
                    if (want_word.disc != 0)
                        n_trimmed++;
                end
                n_out++;
            end
        end
    end

    // valid stays high into the next word when no gap is drawn
    task automatic send_seg(input twt_in_t s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {next_expected, recv_window, seq_in, length_in, flags_in, urgent_in} <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(logic [31:0] nxt, logic [15:0] wnd, logic [31:0] seq,
                               logic [15:0] len, logic [5:0] flags, logic [15:0] up);
        send_seg({nxt, wnd, seq, len, flags, up});
    endtask

    // always lets the clock advance before returning so a following send drives valid in a new step
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (trimmed_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(int sender, int receiver);
        idle_pct  = sender;
        stall_pct = receiver;
    endtask

    function automatic logic [15:0] rand_size(logic nonzero);
        logic [15:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = 16'($urandom_range(40));
            5, 6:          v = 16'($urandom_range(1500));
            7:             v = 16'($urandom_range(65535));
            8:             v = 16'hFFFF - 16'($urandom_range(3));
            default:       v = 16'($urandom_range(3));
        endcase
        if (nonzero && v == 0)
            v = 1;
        return v;
    endfunction

    function automatic logic [15:0] rand_urgent();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(2));
            1:       return 16'($urandom_range(60));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic twt_in_t make_seg(seg_kind_t kind);
        twt_in_t s;
        s.nxt   = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(300) : $urandom;
        s.wnd   = rand_size(1'b1);
        s.len   = rand_size(1'b0);
        s.flags = 6'($urandom_range(63));
        s.up    = rand_urgent();
        s.seq   = $urandom;
        case (kind)
            SEG_INSIDE: s.seq = s.nxt + $urandom_range(s.wnd - 1);
            SEG_LEFT:   s.seq = s.nxt - $urandom_range(s.len + 3, 1);
            SEG_RIGHT:  s.seq = s.nxt + s.wnd - $urandom_range(s.len + 3);
            SEG_ZERO_WIN:
            begin
                s.wnd = '0;
                if ($urandom_range(1))
                    s.flags = s.flags & ~(F_FIN | F_SYN);
                if ($urandom_range(3) != 0)
                    s.len = '0;
                s.seq = ($urandom_range(1)) ? s.nxt : s.nxt + $urandom_range(2) - 1;
            end
            default:
            begin
                s.nxt = $urandom;
                s.wnd = 16'($urandom);
                s.len = 16'($urandom);
            end
        endcase
        return s;
    endfunction

    function automatic seg_kind_t pick_kind(seg_kind_t main);
        if ($urandom_range(99) < 65)
            return main;
        return seg_kind_t'($urandom_range(SEG_NOISE));
    endfunction

    task automatic test_directed();
        logic [31:0] n;
        n = 32'h1000_0000;
        set_idling(0, 0);
        send_fields(n, 16'd0, n, 16'd0, 6'h00, 16'd0);
        send_fields(n, 16'd0, n, 16'd0, F_RST | F_PSH | F_ACK | F_URG, 16'hFFFF);
        send_fields(n, 16'd0, n, 16'd0, F_SYN, 16'd5);
        send_fields(n, 16'd0, n, 16'd1, 6'h00, 16'd0);
        send_fields(n, 16'd0, n + 1, 16'd0, F_ACK, 16'd0);
        send_fields(32'd0, 16'd0, 32'd0, 16'd0, 6'h00, 16'd0);
        send_fields(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F, 16'hFFFF);
        send_fields(n, 16'hFFFF, n, 16'hFFFF, F_FIN, 16'd0);
        send_fields(n, 16'd100, n + 50, 16'd100, F_FIN | F_PSH, 16'd0);
        // leading SYN with urgent pointer at one, two and zero
        send_fields(n, 16'd100, n - 1, 16'd10, F_SYN | F_URG, 16'd1);
        send_fields(n, 16'd100, n - 1, 16'd10, F_SYN | F_URG, 16'd2);
        send_fields(n, 16'd100, n - 1, 16'd10, F_SYN | F_URG, 16'd0);
        // duplicate payload, urgent above, equal to and below the cut
        send_fields(n, 16'd100, n - 5, 16'd10, F_URG, 16'd9);
        send_fields(n, 16'd100, n - 5, 16'd10, F_URG, 16'd5);
        send_fields(n, 16'd100, n - 5, 16'd10, F_SYN | F_URG, 16'd3);
        send_fields(n, 16'd100, n - 10, 16'd10, 6'h00, 16'd0);
        send_fields(n, 16'd100, n - 10, 16'd10, F_FIN, 16'd0);
        send_fields(n, 16'd100, n + 99, 16'd0, 6'h00, 16'd0);
        send_fields(n, 16'd100, n + 100, 16'd0, 6'h00, 16'd0);
        send_fields(n, 16'd100, n + 100, 16'd1, 6'h00, 16'd0);
        send_fields(32'hFFFF_FFF0, 16'd64, 32'hFFFF_FFE0, 16'd48, F_SYN | F_FIN | F_URG, 16'd40);
        send_fields(n, 16'd1, n + 32'h8000_0000, 16'hFFFF, 6'h3F, 16'hFFFF);
        send_fields(n, 16'hFFFF, n - 32'h0000_FFFF, 16'hFFFF, F_SYN | F_FIN, 16'hFFFF);
        wait_drain();
    endtask

    task automatic test_in_window();
        set_idling(0, 0);
        repeat (330)
            send_seg(make_seg(pick_kind(SEG_INSIDE)));
        wait_drain();
    endtask

    task automatic test_left_trim();
        set_idling(61, 0);
        repeat (330)
            send_seg(make_seg(pick_kind(SEG_LEFT)));
        wait_drain();
    endtask

    task automatic test_right_trim();
        set_idling(0, 61);
        repeat (330)
            send_seg(make_seg(pick_kind(SEG_RIGHT)));
        wait_drain();
    endtask

    task automatic test_zero_window();
        set_idling(8, 8);
        repeat (200)
            send_seg(make_seg(pick_kind(SEG_ZERO_WIN)));
        wait_drain();
    endtask

    // every kind mixed, sender holds off until the pipe is empty now and then
    task automatic test_mixed_stream();
        set_idling(8, 8);
        for (int i = 0; i < 430; i++)
        begin
            send_seg(make_seg(seg_kind_t'($urandom_range(SEG_NOISE))));
            if (i % 97 == 96)
                wait_drain();
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_in_window();
        test_left_trim();
        test_right_trim();
        test_zero_window();
        test_mixed_stream();
        set_idling(0, 0);
        repeat (PIPE_LAT * 4) @(posedge clk);
        if (trimmed_q.size() != 0)
            report_mismatch("words never delivered", trimmed_q.size(), 0);
        $display("%0d segments sent, %0d results checked in %0d cycles", n_in, n_out, cycles);
        $display("%0d kept, %0d trimmed, %0d on a zero window; %0d mismatches",
                 n_kept, n_trimmed, n_zero_win, n_err);
        if (n_err == 0)
            $display("PASS tcp_receive_window_trim_top");
        else
            $display("FAIL tcp_receive_window_trim_top");
        $finish;
    end

endmodule
